FILE: sv/wsj_pkg.sv
// Shared types and constants of the windowed sample journal.
package wsj_pkg;

    localparam int SAMPLES_PER_WORD = 4;
    localparam int PACK_W           = 2;
    localparam int IDX_W            = 12;
    localparam int WORDS_W          = 13;
    localparam int ANCHOR_W         = 23;
    localparam int DATA_W           = 32;
    localparam int GAP_W            = 8;

    localparam logic [GAP_W-1:0]  GAP_MAX  = 8'hFF;
    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Result of one transaction, produced by the packer, held in the output stage.
    typedef struct packed {
        logic                  is_read;
        logic                  committed;
        logic                  erased;
        logic                  saturated;
        logic [IDX_W-1:0]      committed_index;
        logic [DATA_W-1:0]     committed_word;
        logic [WORDS_W-1:0]    words_written;
        logic [PACK_W-1:0]     samples_pending;
        logic [ANCHOR_W-1:0]   anchor_window;
        logic                  rd_written;
    } t_result;

endpackage

FILE: sv/windowed_sample_journal_unit.sv
// Windowed sample journal: top level with the three-stage transaction pipeline.
// A transaction passes the input register, the window multiply register and pack/commit
// with memory access into the result register, in that order, before its result is valid.
// Throughput: one transaction per cycle while results are taken; the stages collapse
// bubbles, so input is taken while a result waits at the output as long as one stage is empty.
// Reset (synchronous, active low) clears pipeline valids, cursor, pack count and window
// state at once; the journal memory is never cleared, a slot counts as written below the cursor.
module windowed_sample_journal_unit #(
    parameter int JOURNAL_DEPTH  = 4096,
    parameter int WINDOW_SECONDS = 900
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [31:0]                    i_epoch_seconds,
    input  logic signed [7:0]              i_temperature_half_c,
    input  logic [wsj_pkg::IDX_W-1:0]      i_word_index,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_word_committed,
    output logic                           o_erase_happened,
    output logic                           o_gap_saturated,
    output logic [wsj_pkg::IDX_W-1:0]      o_committed_index,
    output logic [wsj_pkg::DATA_W-1:0]     o_committed_word,
    output logic [wsj_pkg::WORDS_W-1:0]    o_words_written,
    output logic [wsj_pkg::PACK_W-1:0]     o_samples_pending,
    output logic [wsj_pkg::ANCHOR_W-1:0]   o_anchor_window,
    output logic [wsj_pkg::DATA_W-1:0]     o_read_word,
    output logic [wsj_pkg::DATA_W-1:0]     o_read_gaps,
    output logic                           o_read_written
);

    localparam int ADDR_W = $clog2(JOURNAL_DEPTH);
    localparam int CNT_W  = $clog2(JOURNAL_DEPTH + 1);
    localparam logic [63:0] WIN_MAX = 64'hFFFF_FFFF / 64'(WINDOW_SECONDS);
    localparam int WIN_W  = $clog2(WIN_MAX + 64'd1);

    logic                          r_s1_valid, r_s2_valid, r_s3_valid;
    logic                          r_s1_kind, r_s2_kind;
    logic [31:0]                   r_s1_epoch;
    logic [7:0]                    r_s1_temp, r_s2_temp;
    logic [wsj_pkg::IDX_W-1:0]     r_s1_idx, r_s2_idx;
    wsj_pkg::t_result              r_s3_res;
    wsj_pkg::t_result              pack_res;

    logic                          s1_adv, s2_adv;
    logic [WIN_W-1:0]              window;
    logic                          wr_en, rd_en;
    logic [ADDR_W-1:0]             wr_addr, rd_addr;
    logic [wsj_pkg::DATA_W-1:0]    wr_word, wr_gaps, rd_word, rd_gaps;

    always_comb begin
        s2_adv     = r_s2_valid && (!r_s3_valid || i_out_ready);
        s1_adv     = r_s1_valid && (!r_s2_valid || s2_adv);
        o_in_ready = !r_s1_valid || s1_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (!r_s2_valid || s2_adv) begin
                r_s2_valid <= s1_adv;
            end
            if (!r_s3_valid || i_out_ready) begin
                r_s3_valid <= s2_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_kind  <= i_kind;
            r_s1_epoch <= i_epoch_seconds;
            r_s1_temp  <= i_temperature_half_c;
            r_s1_idx   <= i_word_index;
        end
        if (s1_adv) begin
            r_s2_kind <= r_s1_kind;
            r_s2_temp <= r_s1_temp;
            r_s2_idx  <= r_s1_idx;
        end
        if (s2_adv) begin
            r_s3_res <= pack_res;
        end
    end

    wsj_window_div #(
        .WINDOW_SECONDS (WINDOW_SECONDS),
        .WIN_W          (WIN_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_en     (s1_adv),
        .i_epoch  (r_s1_epoch),
        .o_window (window)
    );

    wsj_packer #(
        .JOURNAL_DEPTH (JOURNAL_DEPTH),
        .ADDR_W        (ADDR_W),
        .CNT_W         (CNT_W),
        .WIN_W         (WIN_W)
    ) u_packer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (s2_adv),
        .i_kind    (r_s2_kind),
        .i_window  (window),
        .i_temp    (r_s2_temp),
        .i_idx     (r_s2_idx),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_word (wr_word),
        .o_wr_gaps (wr_gaps),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_res     (pack_res)
    );

    wsj_store #(
        .JOURNAL_DEPTH (JOURNAL_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_word (wr_word),
        .i_wr_gaps (wr_gaps),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_word (rd_word),
        .o_rd_gaps (rd_gaps)
    );

    always_comb begin
        o_out_valid       = r_s3_valid;
        o_word_committed  = r_s3_res.committed;
        o_erase_happened  = r_s3_res.erased;
        o_gap_saturated   = r_s3_res.saturated;
        o_committed_index = r_s3_res.committed_index;
        o_committed_word  = r_s3_res.committed_word;
        o_words_written   = r_s3_res.words_written;
        o_samples_pending = r_s3_res.samples_pending;
        o_anchor_window   = r_s3_res.anchor_window;
        o_read_written    = r_s3_res.rd_written;
        // free or out-of-range slot reads as all ones with zero gaps
        if (r_s3_res.rd_written) begin
            o_read_word = rd_word;
            o_read_gaps = rd_gaps;
        end else begin
            o_read_word = r_s3_res.is_read ? wsj_pkg::ALL_ONES : '0;
            o_read_gaps = '0;
        end
    end

    a_erase_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_erase_happened |->
            o_word_committed && o_committed_index == '0 && o_words_written == 13'd1)
        else $error("erase did not restart the journal at slot zero");

    a_commit_empties_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_committed |-> o_samples_pending == '0 && !o_read_written)
        else $error("commit left samples pending or flagged a read");

    a_full_pipe_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s2_valid && r_s3_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while every stage is blocked");

    a_read_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_written |-> 32'(o_committed_index) == 32'd0 &&
            32'(r_s3_res.words_written) != 32'd0)
        else $error("written read reported with an empty journal");

endmodule

FILE: sv/wsj_window_div.sv
// Window number of a timestamp: exact constant division by reciprocal multiply, registered.
module wsj_window_div #(
    parameter int WINDOW_SECONDS = 900,
    parameter int WIN_W          = 23
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [31:0]       i_epoch,
    output logic [WIN_W-1:0]  o_window
);

    localparam int SHIFT_L = $clog2(WINDOW_SECONDS);
    // ceil(2^(32+L) / d) is exact for every 32-bit dividend
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (32 + SHIFT_L)) + 64'(WINDOW_SECONDS) - 64'd1) / 64'(WINDOW_SECONDS);
    localparam logic [32:0] RECIP = RECIP_FULL[32:0];

    logic [64:0]      prod;
    logic [WIN_W-1:0] n_window;
    logic [WIN_W-1:0] r_window;

    always_comb begin
        prod     = 65'(i_epoch) * 65'(RECIP);
        n_window = WIN_W'(prod >> (32 + SHIFT_L));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_window <= n_window;
        end
    end

    assign o_window = r_window;

endmodule

FILE: sv/wsj_store.sv
// Journal word and gap memory: one write port, one registered read port.
module wsj_store #(
    parameter int JOURNAL_DEPTH = 4096,
    parameter int ADDR_W        = 12
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [wsj_pkg::DATA_W-1:0] i_wr_word,
    input  logic [wsj_pkg::DATA_W-1:0] i_wr_gaps,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [wsj_pkg::DATA_W-1:0] o_rd_word,
    output logic [wsj_pkg::DATA_W-1:0] o_rd_gaps
);

    logic [2*wsj_pkg::DATA_W-1:0] r_mem [0:JOURNAL_DEPTH-1];
    logic [2*wsj_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_gaps, i_wr_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_word = r_rd_data[wsj_pkg::DATA_W-1:0];
    assign o_rd_gaps = r_rd_data[2*wsj_pkg::DATA_W-1:wsj_pkg::DATA_W];

endmodule

FILE: sv/wsj_packer.sv
// Window tracking, pack buffer, write cursor and erase logic of the journal.
module wsj_packer #(
    parameter int JOURNAL_DEPTH = 4096,
    parameter int ADDR_W        = 12,
    parameter int CNT_W         = 13,
    parameter int WIN_W         = 23
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_kind,
    input  logic [WIN_W-1:0]              i_window,
    input  logic [7:0]                    i_temp,
    input  logic [wsj_pkg::IDX_W-1:0]     i_idx,
    output logic                          o_wr_en,
    output logic [ADDR_W-1:0]             o_wr_addr,
    output logic [wsj_pkg::DATA_W-1:0]    o_wr_word,
    output logic [wsj_pkg::DATA_W-1:0]    o_wr_gaps,
    output logic                          o_rd_en,
    output logic [ADDR_W-1:0]             o_rd_addr,
    output wsj_pkg::t_result              o_res
);

    localparam int NBUF = wsj_pkg::SAMPLES_PER_WORD - 1;
    localparam logic [wsj_pkg::PACK_W-1:0] LAST_SLOT = wsj_pkg::PACK_W'(NBUF);
    localparam logic [WIN_W:0] GAP_LIMIT = (WIN_W + 1)'(32'd256);

    // cursor doubles as the word count: both move together and reset together
    logic [CNT_W-1:0]                r_cursor, n_cursor;
    logic [wsj_pkg::PACK_W-1:0]      r_pack_count, n_pack_count;
    logic                            r_seeded, n_seeded;
    logic [WIN_W-1:0]                r_cur_win, n_cur_win;
    logic [7:0]                      r_last_value, n_last_value;
    logic [WIN_W-1:0]                r_first_win, n_first_win;
    logic [WIN_W-1:0]                r_last_rec, n_last_rec;
    logic [WIN_W-1:0]                r_oldest, n_oldest;
    logic [7:0]                      r_pack_val [0:NBUF-1];
    logic [7:0]                      n_pack_val [0:NBUF-1];
    logic [7:0]                      r_pack_gap [0:NBUF-1];
    logic [7:0]                      n_pack_gap [0:NBUF-1];

    logic [WIN_W:0]      diff;
    logic [WIN_W:0]      diff_m1;
    logic                in_range;
    logic                fill_start;
    logic [7:0]          gap;
    logic                erase;
    logic [CNT_W-1:0]    base;

    always_comb begin
        n_cursor     = r_cursor;
        n_pack_count = r_pack_count;
        n_seeded     = r_seeded;
        n_cur_win    = r_cur_win;
        n_last_value = r_last_value;
        n_first_win  = r_first_win;
        n_last_rec   = r_last_rec;
        n_oldest     = r_oldest;
        for (int k = 0; k < NBUF; k++) begin
            n_pack_val[k] = r_pack_val[k];
            n_pack_gap[k] = r_pack_gap[k];
        end

        diff       = {1'b0, r_cur_win} - {1'b0, r_last_rec};
        diff_m1    = diff - (WIN_W + 1)'(1);
        // wrapped gap fits a byte only when 1 <= cur - last <= 256
        in_range   = !diff[WIN_W] && (diff != '0) && (diff <= GAP_LIMIT);
        fill_start = (r_cursor == '0) && (r_pack_count == '0);
        erase      = (r_cursor == CNT_W'(JOURNAL_DEPTH));
        base       = erase ? '0 : r_cursor;
        if (fill_start) begin
            gap = '0;
        end else if (in_range) begin
            gap = diff_m1[7:0];
        end else begin
            gap = wsj_pkg::GAP_MAX;
        end

        o_wr_en   = 1'b0;
        o_wr_addr = ADDR_W'(base);
        o_wr_word = {r_last_value, r_pack_val[2], r_pack_val[1], r_pack_val[0]};
        o_wr_gaps = {gap, r_pack_gap[2], r_pack_gap[1], erase ? 8'd0 : r_pack_gap[0]};
        o_rd_en   = 1'b0;
        o_rd_addr = ADDR_W'(i_idx);

        o_res            = '0;
        o_res.is_read    = (i_kind == wsj_pkg::KIND_READ);
        o_res.rd_written = (32'(i_idx) < 32'(r_cursor));

        if (i_en && i_kind == wsj_pkg::KIND_SAMPLE) begin
            if (!r_seeded) begin
                n_seeded    = 1'b1;
                n_first_win = i_window;
                n_cur_win   = i_window;
            end else if (i_window != r_cur_win) begin
                o_res.saturated = !fill_start && !in_range;
                if (r_pack_count == '0) begin
                    n_oldest = r_cur_win;
                end
                n_last_rec = r_cur_win;
                n_cur_win  = i_window;
                if (r_pack_count != LAST_SLOT) begin
                    for (int k = 0; k < NBUF; k++) begin
                        if (r_pack_count == wsj_pkg::PACK_W'(k)) begin
                            n_pack_val[k] = r_last_value;
                            n_pack_gap[k] = gap;
                        end
                    end
                    n_pack_count = r_pack_count + wsj_pkg::PACK_W'(1);
                end else begin
                    // commit; a full journal is erased and re-anchored first
                    n_pack_count          = '0;
                    o_wr_en               = 1'b1;
                    n_cursor              = base + CNT_W'(1);
                    o_res.committed       = 1'b1;
                    o_res.erased          = erase;
                    o_res.committed_index = wsj_pkg::IDX_W'(base);
                    o_res.committed_word  = o_wr_word;
                    if (erase) begin
                        n_first_win = r_oldest;
                    end
                end
            end
            n_last_value = i_temp;
        end

        if (i_en && i_kind == wsj_pkg::KIND_READ) begin
            o_rd_en = 1'b1;
        end

        o_res.words_written   = wsj_pkg::WORDS_W'(n_cursor);
        o_res.samples_pending = n_pack_count;
        o_res.anchor_window   = wsj_pkg::ANCHOR_W'(n_first_win);
        if (!o_res.is_read) begin
            o_res.rd_written = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor     <= '0;
            r_pack_count <= '0;
            r_seeded     <= 1'b0;
            r_cur_win    <= '0;
            r_last_value <= '0;
            r_first_win  <= '0;
            r_last_rec   <= '0;
        end else if (i_en) begin
            r_cursor     <= n_cursor;
            r_pack_count <= n_pack_count;
            r_seeded     <= n_seeded;
            r_cur_win    <= n_cur_win;
            r_last_value <= n_last_value;
            r_first_win  <= n_first_win;
            r_last_rec   <= n_last_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oldest <= n_oldest;
            for (int k = 0; k < NBUF; k++) begin
                r_pack_val[k] <= n_pack_val[k];
                r_pack_gap[k] <= n_pack_gap[k];
            end
        end
    end

endmodule

FILE: test/tb_windowed_sample_journal_unit.sv
// Self-checking testbench for the windowed sample journal unit.
module tb_windowed_sample_journal_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          JOURNAL_DEPTH  = 4096;
    localparam int          WINDOW_SECONDS = 900;
    localparam int unsigned LAST_WINDOW    = 32'hFFFF_FFFF / WINDOW_SECONDS;

    typedef struct {
        logic                              kind;
        logic [31:0]                       epoch;
        logic signed [7:0]                 temp;
        logic [wsj_pkg::IDX_W-1:0]         index;
    } t_journal_item;

    typedef struct {
        logic                              committed;
        logic                              erased;
        logic                              saturated;
        logic [wsj_pkg::IDX_W-1:0]         committed_index;
        logic [wsj_pkg::DATA_W-1:0]        committed_word;
        logic [wsj_pkg::WORDS_W-1:0]       words_written;
        logic [wsj_pkg::PACK_W-1:0]        samples_pending;
        logic [wsj_pkg::ANCHOR_W-1:0]      anchor_window;
        logic [wsj_pkg::DATA_W-1:0]        read_word;
        logic [wsj_pkg::DATA_W-1:0]        read_gaps;
        logic                              read_written;
    } t_journal_result;

    // Tracks the journal state and the results still owed by the block.
    class t_journal_tracker;
        t_journal_result pending_results[$];
        int unsigned     errors;

        bit [wsj_pkg::WORDS_W-1:0] cursor;
        bit [wsj_pkg::WORDS_W-1:0] word_total;
        bit [wsj_pkg::PACK_W-1:0]  pack_fill;
        bit [7:0]         pack_temp [wsj_pkg::SAMPLES_PER_WORD];
        bit [7:0]         pack_gap  [wsj_pkg::SAMPLES_PER_WORD];
        bit [31:0]        oldest_win;
        bit [31:0]        cur_win;
        bit [31:0]        first_win;
        bit [31:0]        last_queued_win;
        bit               seeded;
        bit [7:0]         last_temp;
        bit [31:0]        word_mem  [JOURNAL_DEPTH];
        bit [31:0]        gap_mem   [JOURNAL_DEPTH];
        bit               slot_used [JOURNAL_DEPTH];

        function new();
            wipe_journal();
        endfunction

        function void wipe_journal();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            cursor     = '0;
            word_total = '0;
        endfunction

        function void record_transaction(t_journal_item it);
            t_journal_result r;
            bit [31:0]       win;
            bit [31:0]       gap;
            int unsigned     slot;
            bit [31:0]       w;
            bit [31:0]       g;
            r = '{default: '0};
            if (it.kind == wsj_pkg::KIND_SAMPLE) begin
                win = it.epoch / WINDOW_SECONDS;
                if (!seeded) begin
                    seeded    = 1'b1;
                    first_win = win;
                    cur_win   = win;
                end else if (win != cur_win) begin
                    gap  = 0;
                    slot = pack_fill;
                    // first sample of a fill cycle carries no gap
                    if (!(word_total == 0 && pack_fill == 0)) begin
                        gap = cur_win - last_queued_win - 1;
                        if (gap > 32'(wsj_pkg::GAP_MAX)) begin
                            gap         = 32'(wsj_pkg::GAP_MAX);
                            r.saturated = 1'b1;
                        end
                    end
                    if (slot == 0) oldest_win = cur_win;
                    pack_gap[slot]  = gap[7:0];
                    pack_temp[slot] = last_temp;
                    last_queued_win = cur_win;
                    if (slot == wsj_pkg::SAMPLES_PER_WORD - 1) begin
                        pack_fill = '0;
                        if (cursor >= JOURNAL_DEPTH) begin
                            wipe_journal();
                            first_win   = oldest_win;
                            pack_gap[0] = 8'h00;
                            r.erased    = 1'b1;
                        end
                        w = {pack_temp[3], pack_temp[2], pack_temp[1], pack_temp[0]};
                        g = {pack_gap[3], pack_gap[2], pack_gap[1], pack_gap[0]};
                        word_mem[cursor[wsj_pkg::IDX_W-1:0]]  = w;
                        gap_mem[cursor[wsj_pkg::IDX_W-1:0]]   = g;
                        slot_used[cursor[wsj_pkg::IDX_W-1:0]] = 1'b1;
                        r.committed       = 1'b1;
                        r.committed_index = cursor[wsj_pkg::IDX_W-1:0];
                        r.committed_word  = w;
                        cursor++;
                        word_total++;
                    end else begin
                        pack_fill = wsj_pkg::PACK_W'(slot + 1);
                    end
                    cur_win = win;
                end
                last_temp = it.temp;
            end else begin
                if (slot_used[it.index]) begin
                    r.read_word    = word_mem[it.index];
                    r.read_gaps    = gap_mem[it.index];
                    r.read_written = 1'b1;
                end else begin
                    r.read_word = wsj_pkg::ALL_ONES;
                end
            end
            r.words_written   = word_total;
            r.samples_pending = pack_fill;
            r.anchor_window   = first_win[wsj_pkg::ANCHOR_W-1:0];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_journal_result act);
            t_journal_result exp_r;
            if (pending_results.size() == 0) begin
                errors++;
                $error("result with no transaction outstanding");
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("word_committed",  exp_r.committed,       act.committed);
            compare_field("erase_happened",  exp_r.erased,          act.erased);
            compare_field("gap_saturated",   exp_r.saturated,       act.saturated);
            compare_field("committed_index", exp_r.committed_index, act.committed_index);
            compare_field("committed_word",  exp_r.committed_word,  act.committed_word);
            compare_field("words_written",   exp_r.words_written,   act.words_written);
            compare_field("samples_pending", exp_r.samples_pending, act.samples_pending);
            compare_field("anchor_window",   exp_r.anchor_window,   act.anchor_window);
            compare_field("read_word",       exp_r.read_word,       act.read_word);
            compare_field("read_gaps",       exp_r.read_gaps,       act.read_gaps);
            compare_field("read_written",    exp_r.read_written,    act.read_written);
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic                              i_kind;
    logic [31:0]                       i_epoch_seconds;
    logic signed [7:0]                 i_temperature_half_c;
    logic [wsj_pkg::IDX_W-1:0]         i_word_index;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic                              o_word_committed;
    logic                              o_erase_happened;
    logic                              o_gap_saturated;
    logic [wsj_pkg::IDX_W-1:0]         o_committed_index;
    logic [wsj_pkg::DATA_W-1:0]        o_committed_word;
    logic [wsj_pkg::WORDS_W-1:0]       o_words_written;
    logic [wsj_pkg::PACK_W-1:0]        o_samples_pending;
    logic [wsj_pkg::ANCHOR_W-1:0]      o_anchor_window;
    logic [wsj_pkg::DATA_W-1:0]        o_read_word;
    logic [wsj_pkg::DATA_W-1:0]        o_read_gaps;
    logic                              o_read_written;

    t_journal_tracker tracker;
    bit               idle_on;
    int unsigned      win_now;

    windowed_sample_journal_unit #(
        .JOURNAL_DEPTH  (JOURNAL_DEPTH),
        .WINDOW_SECONDS (WINDOW_SECONDS)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_kind               (i_kind),
        .i_epoch_seconds      (i_epoch_seconds),
        .i_temperature_half_c (i_temperature_half_c),
        .i_word_index         (i_word_index),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_word_committed     (o_word_committed),
        .o_erase_happened     (o_erase_happened),
        .o_gap_saturated      (o_gap_saturated),
        .o_committed_index    (o_committed_index),
        .o_committed_word     (o_committed_word),
        .o_words_written      (o_words_written),
        .o_samples_pending    (o_samples_pending),
        .o_anchor_window      (o_anchor_window),
        .o_read_word          (o_read_word),
        .o_read_gaps          (o_read_gaps),
        .o_read_written       (o_read_written)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit [31:0] epoch_in_window(int unsigned w);
        bit [31:0]   base;
        int unsigned span;
        base = w * WINDOW_SECONDS;
        span = (w == LAST_WINDOW) ? (32'hFFFF_FFFF - base) : (WINDOW_SECONDS - 1);
        return base + $urandom_range(0, span);
    endfunction

    function automatic t_journal_item sample_item(bit [31:0] epoch, bit [7:0] temp);
        t_journal_item it;
        it.kind  = wsj_pkg::KIND_SAMPLE;
        it.epoch = epoch;
        it.temp  = temp;
        it.index = wsj_pkg::IDX_W'($urandom);
        return it;
    endfunction

    function automatic t_journal_item read_item(int unsigned idx);
        t_journal_item it;
        it.kind  = wsj_pkg::KIND_READ;
        it.epoch = $urandom;
        it.temp  = 8'($urandom);
        it.index = wsj_pkg::IDX_W'(idx);
        return it;
    endfunction

    function automatic int unsigned written_limit();
        return (tracker.cursor > JOURNAL_DEPTH - 1) ? JOURNAL_DEPTH - 1 : tracker.cursor;
    endfunction

    // Mostly forward steps, with same-window repeats, long jumps and time going back.
    function automatic int unsigned next_window(int unsigned w);
        int unsigned pick;
        int unsigned step;
        pick = $urandom_range(0, 99);
        if (pick < 30)      step = 0;
        else if (pick < 75) step = 1;
        else if (pick < 88) step = $urandom_range(2, 10);
        else if (pick < 91) step = $urandom_range(255, 258);
        else if (pick < 94) step = $urandom_range(259, 100000);
        else if (pick < 97) return w - $urandom_range(0, (w < 50) ? w : 50);
        else                return $urandom_range(0, LAST_WINDOW);
        if (w + step > LAST_WINDOW) return $urandom_range(0, 1000);
        return w + step;
    endfunction

    task automatic send_item(input t_journal_item it);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind               <= it.kind;
        i_epoch_seconds      <= it.epoch;
        i_temperature_half_c <= it.temp;
        i_word_index         <= it.index;
        i_in_valid           <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.record_transaction(it);
    endtask

    task automatic run_mixed(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 80 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) begin
                win_now = next_window(win_now);
                send_item(sample_item(epoch_in_window(win_now), 8'($urandom)));
            end else if ($urandom_range(0, 9) < 7) begin
                send_item(read_item($urandom_range(0, written_limit())));
            end else begin
                send_item(read_item($urandom_range(0, JOURNAL_DEPTH - 1)));
            end
        end
    endtask

    // Result side: stall at random, capture each transaction at the rising edge.
    initial begin
        t_journal_result seen;
        int unsigned     stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            seen.committed       = o_word_committed;
            seen.erased          = o_erase_happened;
            seen.saturated       = o_gap_saturated;
            seen.committed_index = o_committed_index;
            seen.committed_word  = o_committed_word;
            seen.words_written   = o_words_written;
            seen.samples_pending = o_samples_pending;
            seen.anchor_window   = o_anchor_window;
            seen.read_word       = o_read_word;
            seen.read_gaps       = o_read_gaps;
            seen.read_written    = o_read_written;
            tracker.check_result(seen);
            @(negedge i_clk);
        end
    end

    initial begin
        tracker              = new();
        idle_on              = 1'b1;
        win_now              = 0;
        i_rst_n              = 1'b0;
        i_in_valid           = 1'b0;
        i_kind               = wsj_pkg::KIND_SAMPLE;
        i_epoch_seconds      = '0;
        i_temperature_half_c = '0;
        i_word_index         = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(read_item(0));                        // nothing written yet
        send_item(sample_item(32'd0, 8'h80));           // seed window and anchor
        send_item(sample_item(32'd899, 8'h7F));         // same window: replace value
        send_item(sample_item(32'd900, 8'h00));         // first of fill cycle, no gap
        send_item(sample_item(32'd1805, 8'h01));
        send_item(sample_item(32'd232200, 8'hFE));      // next queue carries gap 255
        send_item(sample_item(32'd463500, 8'h33));      // commit first word
        send_item(sample_item(32'hFFFF_FFFF, 8'h44));   // gap 256 clamps
        send_item(sample_item(32'd7, 8'h55));           // back to window zero
        send_item(sample_item(32'd901, 8'h66));         // wrapped gap clamps
        send_item(sample_item(32'd1799, 8'h77));
        send_item(sample_item(32'd1800, 8'h88));        // commit second word
        send_item(read_item(0));
        send_item(read_item(1));
        send_item(read_item(2));
        send_item(read_item(JOURNAL_DEPTH - 1));
        win_now = 2;

        run_mixed(900);
        run_mixed(1000);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int k = 0; k < 4000 && tracker.pending_results.size() != 0; k++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.pending_results.size() != 0) begin
            tracker.errors++;
            $error("%0d results never arrived", tracker.pending_results.size());
        end
        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/wsj_pkg.sv
sv/wsj_window_div.sv
sv/wsj_store.sv
sv/wsj_packer.sv
sv/windowed_sample_journal_unit.sv
test/tb_windowed_sample_journal_unit.sv
